/* rtl/tcw_pkg.sv */
package tcw_pkg;

    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'hF0;

    typedef struct packed {
        logic capture;
        logic put;
        logic rd;
        logic clr;
        logic step;
        logic result;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             put_scroll;
        logic             sweep_last;
    } t_dp_sts;

endpackage

/* rtl/tcw_in_if.sv */
interface tcw_in_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, output cmd, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input cmd, input char_code, input cell_index,
                  output ready);
endinterface

/* rtl/tcw_out_if.sv */
interface tcw_out_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
    logic              did_scroll;

    modport source (output valid, output cursor_position, output cell_data,
                    output did_scroll, input ready);
    modport sink (input valid, input cursor_position, input cell_data,
                  input did_scroll, output ready);
endinterface

/* rtl/tcw_ctrl.sv */
module tcw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tcw_pkg::t_dp_sts  i_sts,
    output tcw_pkg::t_dp_cmd  o_ctl
);
    import tcw_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_ctl   = '0;
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                o_ctl.step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.cmd)
                    CMD_PUT: begin
                        o_ctl.put = 1'b1;
                        n_state   = i_sts.put_scroll ? S_SWEEP : S_FINISH;
                    end
                    CMD_READ: begin
                        o_ctl.rd = 1'b1;
                        n_state  = S_FINISH;
                    end
                    CMD_CLEAR: begin
                        o_ctl.clr = 1'b1;
                        n_state   = S_SWEEP;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SWEEP: begin
                o_ctl.step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_ctl.result = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

/* rtl/tcw_datapath.sv */
module tcw_datapath #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_wdata,
    input  logic [tcw_pkg::CMD_W-1:0]   i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]   i_cell_index,
    input  tcw_pkg::t_dp_cmd            i_ctl,
    output tcw_pkg::t_dp_sts            o_sts,
    output logic [tcw_pkg::POS_W-1:0]   o_cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]  o_cell_data,
    output logic                        o_did_scroll
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int LW    = (AW > POS_W) ? AW : POS_W;

    logic [CELL_W-1:0] r_mem [CELLS];

    logic [CMD_W-1:0]  r_cmd;
    logic [CHAR_W-1:0] r_char;
    logic [IDX_W-1:0]  r_idx;
    logic [ATTR_W-1:0] r_attr;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_row;
    logic [AW-1:0]     r_off;
    logic [AW-1:0]     r_sweep_addr;
    logic [AW-1:0]     r_sweep_left;
    logic [CELL_W-1:0] r_sweep_data;
    logic [CELL_W-1:0] r_rd_data;
    logic              r_rd_ok;
    logic              r_scroll;
    logic [POS_W-1:0]  r_pos_q;
    logic [CELL_W-1:0] r_cell_q;
    logic              r_scroll_q;

    // ring mapping: logical cell plus row offset, wrapped once
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] a, input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, off};
        if (s >= (AW+1)'(CELLS)) begin
            s = s - (AW+1)'(CELLS);
        end
        return s[AW-1:0];
    endfunction

    logic [LW-1:0]     cur_lin;
    logic [CW:0]       col_inc;
    logic              newline;
    logic              wrap;
    logic              last_row;
    logic              put_scroll;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     off_next;
    logic [LW-1:0]     idx_l;
    logic              rd_ok;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [CELL_W-1:0] blank;

    assign cur_lin    = LW'(r_row) * LW'(COLS) + LW'(r_col);
    assign col_inc    = {1'b0, r_col} + (CW+1)'(1);
    assign newline    = (r_char == NEWLINE_CODE);
    assign wrap       = newline || (col_inc == (CW+1)'(COLS));
    assign last_row   = (r_row == RW'(ROWS - 1));
    assign put_scroll = wrap && last_row;
    assign cur_addr   = phys(cur_lin[AW-1:0], r_off);
    assign off_next   = phys(AW'(COLS), r_off);
    assign idx_l      = LW'(r_idx);
    assign rd_ok      = ({1'b0, idx_l} < (LW+1)'(CELLS));
    assign rd_addr    = phys(idx_l[AW-1:0], r_off);
    assign blank      = {r_attr, SPACE_CODE};

    assign mem_we    = i_ctl.step || (i_ctl.put && !newline);
    assign mem_waddr = i_ctl.step ? r_sweep_addr : cur_addr;
    assign mem_wdata = i_ctl.step ? r_sweep_data : {r_attr, r_char};

    assign o_sts.cmd        = r_cmd;
    assign o_sts.put_scroll = put_scroll;
    assign o_sts.sweep_last = (r_sweep_left == '0);

    assign o_cursor_position = r_pos_q;
    assign o_cell_data       = r_cell_q;
    assign o_did_scroll      = r_scroll_q;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd  <= i_cmd;
            r_char <= i_char_code;
            r_idx  <= i_cell_index;
        end
        if (i_ctl.rd) begin
            r_rd_ok <= rd_ok;
        end
        if (i_ctl.result) begin
            r_pos_q    <= cur_lin[POS_W-1:0];
            r_cell_q   <= (r_cmd == CMD_READ && r_rd_ok) ? r_rd_data : '0;
            r_scroll_q <= r_scroll;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr       <= ATTR_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_off        <= '0;
            r_scroll     <= 1'b0;
            r_sweep_addr <= '0;
            r_sweep_left <= AW'(CELLS - 1);
            r_sweep_data <= {ATTR_RESET, SPACE_CODE};
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            if (i_ctl.put) begin
                r_col <= wrap ? '0 : col_inc[CW-1:0];
                if (wrap && !last_row) begin
                    r_row <= r_row + RW'(1);
                end
                if (put_scroll) begin
                    r_off        <= off_next;
                    r_scroll     <= 1'b1;
                    r_sweep_addr <= r_off;
                    r_sweep_left <= AW'(COLS - 1);
                    r_sweep_data <= blank;
                end
            end else if (i_ctl.clr) begin
                r_col        <= '0;
                r_row        <= '0;
                r_off        <= '0;
                r_sweep_addr <= '0;
                r_sweep_left <= AW'(CELLS - 1);
                r_sweep_data <= blank;
            end else if (i_ctl.step) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
                r_sweep_left <= r_sweep_left - AW'(1);
            end
            if (i_ctl.result) begin
                r_scroll <= 1'b0;
            end
        end
    end
endmodule

/* rtl/text_console_char_writer.sv */
// Text console engine with a ROWS x COLS screen of 16-bit cells (attribute in
// the high byte, character in the low byte) kept in one memory with a single
// write port and a separate read port. One request is taken at a time: put,
// read and unused commands go through accept, decode/memory access, result
// register and handoff before the next beat is accepted. A scroll is done by
// moving a row offset through the memory as a ring, so it only blanks the new
// bottom row; clear blanks every cell. After reset the screen is blanked by a
// pass over every cell during which no request is taken; attribute writes are
// taken always. The memory's single write port sets the blanking rate, one
// cell per cycle.
module text_console_char_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata,
    tcw_in_if.sink                     i_req,
    tcw_out_if.source                  o_rsp
);
    import tcw_pkg::*;

    t_dp_cmd ctl;
    t_dp_sts sts;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    tcw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_cmd             (i_req.cmd),
        .i_char_code       (i_req.char_code),
        .i_cell_index      (i_req.cell_index),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .o_cursor_position (o_rsp.cursor_position),
        .o_cell_data       (o_rsp.cell_data),
        .o_did_scroll      (o_rsp.did_scroll)
    );

    a_no_accept_with_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("request taken while a result beat is pending");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !o_rsp.valid)
        else $error("result beat shown in the cycle after accept");

    a_scroll_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.did_scroll) |-> (o_rsp.cell_data == '0))
        else $error("scroll result carries cell data");

    a_sweep_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.step |-> !i_req.ready)
        else $error("request taken during a blanking sweep");
endmodule

/* tb/sv/text_console_char_writer_test.sv */
module text_console_char_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int CELLS = COLS * ROWS;
    localparam int N_PHASES  = 4;
    localparam int PHASE_LEN = 400;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] data;
        logic              scroll;
    } t_report;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic [7:0]        reps;
        logic              typed;
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] data;
        logic              scroll;
    } t_dir_row;

    // typed rows carry their expected report; the others go through the shadow screen
    localparam t_dir_row DIRECTED [20] = '{
        '{CMD_READ,  8'h00,        11'd0,    8'd1,  1'b1, 11'd0,    16'hF020, 1'b0},
        '{CMD_READ,  8'h00,        11'd1999, 8'd1,  1'b1, 11'd0,    16'hF020, 1'b0},
        '{CMD_READ,  8'hFF,        11'd2000, 8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
        '{CMD_READ,  8'h00,        11'd2047, 8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
        '{CMD_NONE,  8'hFF,        11'd2047, 8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
        '{CMD_PUT,   8'h41,        11'd0,    8'd1,  1'b1, 11'd1,    16'h0000, 1'b0},
        '{CMD_READ,  8'h00,        11'd0,    8'd1,  1'b1, 11'd1,    16'hF041, 1'b0},
        '{CMD_PUT,   NEWLINE_CODE, 11'd0,    8'd1,  1'b1, 11'd80,   16'h0000, 1'b0},
        '{CMD_PUT,   8'hFF,        11'd0,    8'd1,  1'b1, 11'd81,   16'h0000, 1'b0},
        '{CMD_PUT,   8'h00,        11'd0,    8'd1,  1'b1, 11'd82,   16'h0000, 1'b0},
        '{CMD_READ,  8'h00,        11'd80,   8'd1,  1'b1, 11'd82,   16'hF0FF, 1'b0},
        '{CMD_READ,  8'h00,        11'd81,   8'd1,  1'b1, 11'd82,   16'hF000, 1'b0},
        '{CMD_PUT,   8'h0B,        11'd0,    8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
        '{CMD_CLEAR, 8'h00,        11'd0,    8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
        '{CMD_READ,  8'h00,        11'd80,   8'd1,  1'b1, 11'd0,    16'hF020, 1'b0},
        '{CMD_PUT,   NEWLINE_CODE, 11'd0,    8'd24, 1'b0, 11'd0,    16'h0000, 1'b0},
        '{CMD_PUT,   8'h45,        11'd0,    8'd1,  1'b1, 11'd1921, 16'h0000, 1'b0},
        '{CMD_PUT,   NEWLINE_CODE, 11'd0,    8'd1,  1'b1, 11'd1920, 16'h0000, 1'b1},
        '{CMD_READ,  8'h00,        11'd1840, 8'd1,  1'b1, 11'd1920, 16'hF045, 1'b0},
        '{CMD_READ,  8'h00,        11'd1920, 8'd1,  1'b1, 11'd1920, 16'hF020, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ATTR_W-1:0] i_cfg_wdata;

    tcw_in_if  req_if ();
    tcw_out_if rsp_if ();

    text_console_char_writer #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    // shadow of the screen and cursor
    logic [CELL_W-1:0] shadow_cells [CELLS];
    int                shadow_col;
    int                shadow_row;
    logic [ATTR_W-1:0] shadow_attr;

    t_report pending_reports [$];
    t_report head_report;

    int mismatches = 0;
    int n_items    = 0;
    int n_checked  = 0;
    int n_reads    = 0;
    int n_clears   = 0;
    int n_scrolls  = 0;
    int burst_left = 1;

    task automatic console_step(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] ix, output t_report r);
        int pos;
        r = '0;
        case (c)
            CMD_PUT: begin
                if (ch == NEWLINE_CODE) begin
                    shadow_col = 0;
                    shadow_row++;
                end else begin
                    pos = shadow_row * COLS + shadow_col;
                    if (pos < CELLS) shadow_cells[pos] = {shadow_attr, ch};
                    shadow_col++;
                end
                if (shadow_col >= COLS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (shadow_row >= ROWS) begin
                    for (int i = 0; i + COLS < CELLS; i++)
                        shadow_cells[i] = shadow_cells[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        shadow_cells[i] = {shadow_attr, SPACE_CODE};
                    shadow_row = ROWS - 1;
                    r.scroll = 1'b1;
                end
            end
            CMD_READ: begin
                if (ix < CELLS) r.data = shadow_cells[ix];
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_attr, SPACE_CODE};
                shadow_col = 0;
                shadow_row = 0;
            end
            default: ;
        endcase
        r.pos = POS_W'(shadow_row * COLS + shadow_col);
    endtask

    // drive one beat, wait for acceptance, then log the expected report
    task automatic send_beat(input logic [CMD_W-1:0] c, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] ix, input logic typed,
                             input t_report want);
        t_report pred;
        req_if.valid      <= 1'b1;
        req_if.cmd        <= c;
        req_if.char_code  <= ch;
        req_if.cell_index <= ix;
        do @(posedge i_clk); while (!req_if.ready);
        console_step(c, ch, ix, pred);
        pending_reports.push_back(typed ? want : pred);
        n_items++;
        if (c == CMD_READ) n_reads++;
        if (c == CMD_CLEAR) n_clears++;
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic note_bad(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0d (0x%0h), got %0d (0x%0h) at %0t",
                     what, want, want, got, got, $realtime);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_reports.size() == 0) begin
                note_bad("result beat with nothing pending", 0, rsp_if.cursor_position);
            end else begin
                head_report = pending_reports.pop_front();
                n_checked++;
                if (rsp_if.did_scroll) n_scrolls++;
                if (rsp_if.cursor_position !== head_report.pos)
                    note_bad("cursor_position", head_report.pos, rsp_if.cursor_position);
                if (rsp_if.cell_data !== head_report.data)
                    note_bad("cell_data", head_report.data, rsp_if.cell_data);
                if (rsp_if.did_scroll !== head_report.scroll)
                    note_bad("did_scroll", head_report.scroll, rsp_if.did_scroll);
            end
        end
    end

    // receiver: rotating stall pattern, plus two long hold-offs to back up the input
    initial begin
        int beats;
        int hold;
        int k;
        logic [15:0] pat;
        beats = 0;
        hold  = 0;
        k     = 0;
        pat   = '1;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                beats++;
                if (beats == 300 || beats == 1000) hold = 600;
            end
            if (k % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: pat = '1;
                    1: pat = 16'($urandom);
                    2: pat = 16'($urandom & $urandom);
                    default: pat = 16'($urandom | $urandom);
                endcase
                if (pat == 16'd0) pat = 16'd1;
            end
            if (hold > 0) begin
                hold--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= pat[k % 16];
            end
            k++;
        end
    end

    initial begin
        #8_000_000;
        $display("Timeout waiting for result beats");
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int nl_odds [N_PHASES];
        int roll;
        int p;
        logic [CMD_W-1:0]  c;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  ix;
        logic [ATTR_W-1:0] attr;

        nl_odds = '{4, 40, 10, 60};
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_PUT;
        req_if.char_code  = '0;
        req_if.cell_index = '0;
        shadow_attr = ATTR_RESET;
        shadow_col  = 0;
        shadow_row  = 0;
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = {ATTR_RESET, SPACE_CODE};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r])
            repeat (DIRECTED[r].reps)
                send_beat(DIRECTED[r].cmd, DIRECTED[r].ch, DIRECTED[r].idx, DIRECTED[r].typed,
                          '{DIRECTED[r].pos, DIRECTED[r].data, DIRECTED[r].scroll});

        for (int ph = 0; ph < N_PHASES; ph++) begin
            req_if.valid <= 1'b0;
            while (pending_reports.size() != 0) @(posedge i_clk);
            repeat (CELLS + 16) @(posedge i_clk);
            case (ph)
                0: attr = 8'h00;
                1: attr = 8'hFF;
                2: attr = 8'($urandom);
                default: attr = 8'h1E;
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= attr;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            shadow_attr = attr;
            @(posedge i_clk);

            for (int n = 0; n < PHASE_LEN; n++) begin
                roll = $urandom_range(0, 199);
                ch = 8'($urandom);
                ix = 11'($urandom);
                if (roll == 0) begin
                    c = CMD_CLEAR;
                end else if (roll < 5) begin
                    c = CMD_NONE;
                end else if (roll < 130) begin
                    c = CMD_PUT;
                    if ($urandom_range(1, nl_odds[ph]) == 1) ch = NEWLINE_CODE;
                end else begin
                    c = CMD_READ;
                    roll = $urandom_range(0, 9);
                    if (roll < 5) begin
                        // recently written cells, occasionally wrapping below zero
                        p  = shadow_row * COLS + shadow_col - $urandom_range(0, 90);
                        ix = IDX_W'(p);
                    end else if (roll < 9) begin
                        ix = IDX_W'($urandom_range(0, CELLS - 1));
                    end
                end
                send_beat(c, ch, ix, 1'b0, '0);
            end
        end

        req_if.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Covered %0d requests (%0d reads, %0d clears), %0d result beats compared",
                 n_items, n_reads, n_clears, n_checked);
        $display("Screen scrolled %0d times across %0d attribute settings",
                 n_scrolls, N_PHASES + 1);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
